FILE: rtl/distinct_partition_count_defines.svh
// ============================================================================
// distinct_partition_count_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef DISTINCT_PARTITION_COUNT_DEFINES_SVH
`define DISTINCT_PARTITION_COUNT_DEFINES_SVH

// Same-cycle implication.
`define DPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dpc_pkg.sv
// ============================================================================
// dpc_pkg: shared types and constants
// Command and status bundles between controller and datapath, field widths.
// ============================================================================
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int N_VALUE_W   = 10;
    localparam int COUNT_W     = 64;

    // Start of the two offset passes of the recurrence and the step growth.
    localparam int PASS_A_R    = 2;
    localparam int PASS_A_STEP = 5;
    localparam int PASS_B_R    = 1;
    localparam int PASS_B_STEP = 4;
    localparam int STEP_INC    = 3;

    typedef struct packed {
        logic load_n;
        logic init_wr;
        logic init_sel;
        logic start_i;
        logic issue;
        logic switch_pass;
        logic write_i;
        logic load_out;
    } dpc_cmd_t;

    typedef struct packed {
        logic n_over;
        logic n_small;
        logic r_le_i;
        logic pass_b;
        logic i_eq_n;
        logic slot_free;
    } dpc_status_t;

endpackage

FILE: rtl/distinct_partition_count.sv
// ============================================================================
// distinct_partition_count: partitions of n into distinct parts, q(n)
// Throughput: one request at a time; rate set by the single table read port (one term a cycle).
// Reset: rst_n async, active low; clears control and output valid, table is left as is.
// ============================================================================
`timescale 1ns / 1ps

module distinct_partition_count #(
    parameter int MAX_N = 511
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dpc_pkg::N_VALUE_W-1:0] n_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dpc_pkg::COUNT_W-1:0]   count,
    output logic                          range_error
);
    import dpc_pkg::*;

    // How it works:
    // A request is taken only while the sequencer is idle. The table is seeded
    // with q(0) = q(1) = 1, then each row i from 2 to n is built in turn: the
    // offset generator walks the first pass (2, 7, 15, ...) and the second
    // pass (1, 5, 12, ...), issuing one table read per cycle. Each read
    // result is registered and in the next cycle added or subtracted into a 64-bit
    // accumulator, with the extra correction when i is twice the offset.
    // Arithmetic wraps modulo 2^64, which is exact since q(i) fits for every
    // supported n. The finished row is written back and becomes the result
    // on the last row. Out-of-range requests skip the table entirely.
    //
    // The output register frees the sequencer: the next request is accepted
    // while a finished result still waits downstream; a new result only holds
    // in the done state if the previous one has not been taken yet.

    dpc_cmd_t    cmd;
    dpc_status_t status;

    dpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dpc_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .n_value     (n_value),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .count       (count),
        .range_error (range_error)
    );

endmodule

FILE: rtl/dpc_ctrl.sv
// ============================================================================
// dpc_ctrl: sequencer for the pentagonal recurrence
// Walks request intake, table seeding, term issue, row write and result hand-off.
// ============================================================================
`timescale 1ns / 1ps

module dpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dpc_pkg::dpc_status_t status,
    output dpc_pkg::dpc_cmd_t    cmd
);
    import dpc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT0 = 3'd1;
    localparam logic [2:0] S_INIT1 = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_n = 1'b1;
                    state_next = status.n_over ? S_DONE : S_INIT0;
                end
            end
            S_INIT0:
            begin
                cmd.init_wr  = 1'b1;
                cmd.init_sel = 1'b0;
                state_next   = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.init_wr  = 1'b1;
                cmd.init_sel = 1'b1;
                cmd.start_i  = 1'b1;
                state_next   = status.n_small ? S_DONE : S_LOOP;
            end
            S_LOOP:
            begin
                if (status.r_le_i)
                    cmd.issue = 1'b1;
                else if (!status.pass_b)
                    cmd.switch_pass = 1'b1;
                else
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_i = 1'b1;
                state_next  = status.i_eq_n ? S_DONE : S_LOOP;
            end
            S_DONE:
            begin
                if (status.slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/dpc_datapath.sv
// ============================================================================
// dpc_datapath: table, offset generator, accumulator and output register
// One table read per cycle feeds the signed accumulate of the next cycle.
// ============================================================================
`timescale 1ns / 1ps
`include "distinct_partition_count_defines.svh"

module dpc_datapath #(
    parameter int MAX_N = 511
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dpc_pkg::dpc_cmd_t                cmd,
    output dpc_pkg::dpc_status_t             status,
    input  logic [dpc_pkg::N_VALUE_W-1:0]    n_value,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [dpc_pkg::COUNT_W-1:0]      count,
    output logic                             range_error
);
    import dpc_pkg::*;

    localparam int DEPTH = MAX_N + 1;
    localparam int NW    = $clog2(DEPTH);
    localparam int RW    = NW + 1;
    localparam logic [N_VALUE_W-1:0] MAX_N_V = N_VALUE_W'(MAX_N);

    logic [COUNT_W-1:0] mem [DEPTH];

    logic [NW-1:0]      n_reg,      n_next;
    logic [NW-1:0]      i_reg,      i_next;
    logic [RW-1:0]      r_reg,      r_next;
    logic [RW-1:0]      step_reg,   step_next;
    logic               pos_reg,    pos_next;
    logic               pass_b_reg, pass_b_next;
    logic [COUNT_W-1:0] acc_reg,    acc_next;
    logic [COUNT_W-1:0] res_reg,    res_next;
    logic               err_reg,    err_next;
    logic               rd_valid_reg;
    logic               rd_pos_reg;
    logic               rd_tw_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               range_error_reg, range_error_next;

    logic [RW-1:0]      diff;
    logic [NW-1:0]      rd_addr;
    logic               tw;
    logic               mem_we;
    logic [NW-1:0]      mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] acc_add;
    logic [COUNT_W-1:0] acc_sub;

    assign diff    = {1'b0, i_reg} - r_reg;
    assign rd_addr = diff[NW-1:0];
    assign tw      = ({2'b00, i_reg} == {r_reg, 1'b0});

    assign acc_add = acc_reg + rd_data_reg - COUNT_W'(rd_tw_reg);
    assign acc_sub = acc_reg - rd_data_reg + COUNT_W'(rd_tw_reg);

    assign status.n_over    = (n_value > MAX_N_V);
    assign status.n_small   = (n_reg < NW'(2));
    assign status.r_le_i    = (r_reg <= {1'b0, i_reg});
    assign status.pass_b    = pass_b_reg;
    assign status.i_eq_n    = (i_reg == n_reg);
    assign status.slot_free = !out_valid_reg || !out_stall;

    assign mem_we    = cmd.init_wr || cmd.write_i;
    assign mem_waddr = cmd.init_wr ? (cmd.init_sel ? NW'(1) : NW'(0)) : i_reg;
    assign mem_wdata = cmd.init_wr ? COUNT_W'(1) : acc_reg;

    always_comb
    begin
        n_next           = n_reg;
        i_next           = i_reg;
        r_next           = r_reg;
        step_next        = step_reg;
        pos_next         = pos_reg;
        pass_b_next      = pass_b_reg;
        acc_next         = acc_reg;
        res_next         = res_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg;
        count_next       = count_reg;
        range_error_next = range_error_reg;

        if (cmd.load_n)
        begin
            n_next   = n_value[NW-1:0];
            res_next = '0;
            err_next = status.n_over;
        end

        // Begin a fresh row: offsets restart at the first pass.
        if (cmd.start_i || cmd.write_i)
        begin
            r_next      = RW'(PASS_A_R);
            step_next   = RW'(PASS_A_STEP);
            pos_next    = 1'b1;
            pass_b_next = 1'b0;
        end
        if (cmd.start_i)
        begin
            i_next   = NW'(2);
            res_next = COUNT_W'(1);
            err_next = 1'b0;
        end
        if (cmd.write_i)
        begin
            i_next   = i_reg + NW'(1);
            res_next = acc_reg;
        end

        if (cmd.issue)
        begin
            r_next    = r_reg + step_reg;
            step_next = step_reg + RW'(STEP_INC);
            pos_next  = !pos_reg;
        end
        if (cmd.switch_pass)
        begin
            r_next      = RW'(PASS_B_R);
            step_next   = RW'(PASS_B_STEP);
            pos_next    = 1'b1;
            pass_b_next = 1'b1;
        end

        if (rd_valid_reg)
            acc_next = rd_pos_reg ? acc_add : acc_sub;
        else if (cmd.start_i || cmd.write_i)
            acc_next = '0;

        if (cmd.load_out)
        begin
            out_valid_next   = 1'b1;
            count_next       = res_reg;
            range_error_next = err_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        i_reg           <= i_next;
        r_reg           <= r_next;
        step_reg        <= step_next;
        pos_reg         <= pos_next;
        pass_b_reg      <= pass_b_next;
        acc_reg         <= acc_next;
        res_reg         <= res_next;
        err_reg         <= err_next;
        rd_pos_reg      <= pos_reg;
        rd_tw_reg       <= tw;
        count_reg       <= count_next;
        range_error_reg <= range_error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.issue;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign count       = count_reg;
    assign range_error = range_error_reg;

    `DPC_ASSERT_NOW(a_issue_in_range, cmd.issue, status.r_le_i,
        "table read issued past the current row")
    `DPC_ASSERT_NOW(a_write_after_drain, cmd.write_i, !rd_valid_reg,
        "row written before its last term was accumulated")
    `DPC_ASSERT_NOW(a_load_into_free_slot, cmd.load_out, status.slot_free,
        "result loaded over a pending result")
    `DPC_ASSERT_NOW(a_error_count_zero, out_valid_reg && range_error_reg, count_reg == '0,
        "range error reported with a nonzero count")

endmodule

FILE: tb/dpc_tb_pkg.sv
// ============================================================================
// dpc_tb_pkg: scoreboard for the distinct-part partition counter
// Predicts q(n) with the pentagonal recurrence on 64-bit wrapping integers
// and matches each returned count and range flag against the oldest request.
// ============================================================================
`timescale 1ns / 1ps

package dpc_tb_pkg;

    import dpc_pkg::*;

    localparam int TB_MAX_N = 511;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               range_error;
    } dpc_result_t;

    class partition_scoreboard;

        dpc_result_t        pending_counts[$];
        logic [COUNT_W-1:0] q_table[TB_MAX_N+1];
        int unsigned        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // One pass over the offsets r, r+step, ... with alternating sign;
        // drop the sign once more when i is exactly twice the offset.
        function logic [COUNT_W-1:0] pentagonal_sum(int unsigned i, int unsigned r,
                                                    int unsigned step,
                                                    logic [COUNT_W-1:0] acc);
            bit positive;
            positive = 1'b1;
            while (r <= i) begin
                if (positive) begin
                    acc += q_table[i - r];
                    if (i == 2 * r) acc -= 1;
                end
                else begin
                    acc -= q_table[i - r];
                    if (i == 2 * r) acc += 1;
                end
                r += step;
                step += STEP_INC;
                positive = !positive;
            end
            return acc;
        endfunction

        function dpc_result_t distinct_count_for(logic [N_VALUE_W-1:0] n);
            dpc_result_t        res;
            logic [COUNT_W-1:0] acc;
            if (n > TB_MAX_N) begin
                res.count       = '0;
                res.range_error = 1'b1;
                return res;
            end
            q_table[0] = 1;
            q_table[1] = 1;
            for (int unsigned i = 2; i <= n; i++) begin
                acc = '0;
                acc = pentagonal_sum(i, PASS_A_R, PASS_A_STEP, acc);
                acc = pentagonal_sum(i, PASS_B_R, PASS_B_STEP, acc);
                q_table[i] = acc;
            end
            res.count       = q_table[n];
            res.range_error = 1'b0;
            return res;
        endfunction

        function void note_request(logic [N_VALUE_W-1:0] n);
            pending_counts.push_back(distinct_count_for(n));
        endfunction

        function void check_result(logic [COUNT_W-1:0] got_count, logic got_error);
            dpc_result_t want;
            if (pending_counts.size() == 0) begin
                $error("unexpected result: count %0d range_error %0b", got_count, got_error);
                mismatches++;
                return;
            end
            want = pending_counts.pop_front();
            if (got_count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got_count);
                mismatches++;
            end
            if (got_error !== want.range_error) begin
                $error("range_error: expected %0b, got %0b", want.range_error, got_error);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_counts.size();
        endfunction

    endclass

endpackage

FILE: tb/tb_top.sv
// ============================================================================
// tb_top: testbench for distinct_partition_count
// Sends n values (directed corners, then random with mostly small n), idles
// and stalls both sides in three phases, holds the output off once to back
// up the block, and checks every count against the scoreboard prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import dpc_pkg::*;
    import dpc_tb_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 50;
    // Worst case: ~100 requests all at n = 511, plus stalls;
    // take that several times over.
    localparam int CYCLE_LIMIT  = 6_000_000;
    localparam int RANDOM_ITEMS = 72;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [N_VALUE_W-1:0] n_value     = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [COUNT_W-1:0]   count;
    logic                 range_error;

    // Idle and stall rates in percent; hold_armed kicks off one long hold-off.
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    logic                 hold_armed     = 1'b0;
    int                   hold_left      = 0;
    int unsigned          cycle_count    = 0;

    partition_scoreboard  sb;

    distinct_partition_count #(
        .MAX_N(TB_MAX_N)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .n_value    (n_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .count      (count),
        .range_error(range_error)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL distinct_partition_count");
            $finish;
        end
    end

    // Receive side: check each accepted result against the oldest request,
    // then pick the stall for the next cycle. A long hold-off, once armed,
    // overrides the random stall until its count runs out.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(count, range_error);
            if (hold_armed) begin
                hold_left = HOLD_CYCLES;
                hold_armed <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one request: idle for a random stretch, then hold valid and the
    // payload steady until the block takes it.
    task automatic send_request(input logic [N_VALUE_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        n_value  <= n;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(n);
    endtask

    // Keep most n small since larger n take much longer; a few reach the top
    // of the table and some land above it to take the range-error path.
    function automatic logic [N_VALUE_W-1:0] pick_n();
        int unsigned bucket;
        bucket = $urandom_range(99);
        if (bucket < 55)
            return N_VALUE_W'($urandom_range(40));
        else if (bucket < 75)
            return N_VALUE_W'($urandom_range(200, 41));
        else if (bucket < 82)
            return N_VALUE_W'($urandom_range(TB_MAX_N, 201));
        else if (bucket < 85)
            return N_VALUE_W'(TB_MAX_N);
        else
            return N_VALUE_W'($urandom_range((1 << N_VALUE_W) - 1, TB_MAX_N + 1));
    endfunction

    // Directed corners: n of zero and one, the cases where i hits twice an
    // offset (2, 4, 10, 14, 24, 30), the top of the table, just above it,
    // all ones, and alternating bit patterns.
    localparam int N_DIRECTED = 21;
    localparam logic [N_VALUE_W-1:0] DIRECTED_N[N_DIRECTED] = '{
        10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd9, 10'd10,
        10'd14, 10'd24, 10'd30, 10'd170, 10'd341, 10'd511, 10'd512, 10'd1023,
        10'd700, 10'd681, 10'd256
    };

    initial
    begin
        sb = new();

        // Hold reset low, then release it at a rising edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase A: sender idles often, receiver stalls most of the time.
        send_idle_pct  = 31;
        recv_stall_pct <= 85;
        foreach (DIRECTED_N[k])
            send_request(DIRECTED_N[k]);
        for (int k = 0; k < RANDOM_ITEMS / 3; k++)
            send_request(pick_n());

        // Phase B: swap the two rates.
        send_idle_pct  = 85;
        recv_stall_pct <= 31;
        for (int k = 0; k < RANDOM_ITEMS / 3; k++)
            send_request(pick_n());

        // Phase C: no idling. Start with a long receive hold-off while small
        // requests keep coming, so the block backs up and stalls its input.
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
        hold_armed     <= 1'b1;
        for (int k = 0; k < 6; k++)
            send_request(N_VALUE_W'($urandom_range(12)));
        for (int k = 0; k < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); k++)
            send_request(pick_n());
        in_valid <= 1'b0;

        // Drain: wait for every answer, then a little longer for strays.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("PASS distinct_partition_count");
        else
            $display("FAIL distinct_partition_count");
        $finish;
    end

endmodule
